/* src/afcp_pkg.sv */
package afcp_pkg;

   localparam int SAMPLE_W         = 24;
   localparam int CH_W             = 3;
   localparam int DEF_CHANNELS     = 8;
   localparam int DEF_HEADER_BYTES = 3;

   localparam logic [15:0] CRC_POLY = 16'h8005;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       frame_start;
   } in_type;

   typedef struct packed {
      logic [CH_W-1:0]            channel;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       crc_error;
      logic                       last;
   } out_type;

   // one cell moves: shift strobe and the word entering it
   typedef struct packed {
      logic                shift;
      logic [SAMPLE_W-1:0] data;
   } cell_ctl_type;

   // crc-16, msb first, no reflection, no final xor
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* src/afcp_cell.sv */
module afcp_cell (
   input  logic                  clock,
   input  afcp_pkg::cell_ctl_type ctl,
   output logic [afcp_pkg::SAMPLE_W-1:0] data_out
);
   import afcp_pkg::*;

   logic [SAMPLE_W-1:0] word_ff;

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         word_ff <= ctl.data;
      end
   end

   assign data_out = word_ff;

endmodule

/* src/adc_frame_crc_parser_core.sv */
// Parses ADC frames arriving one byte per transfer: HEADER_BYTES status bytes, CHANNELS
// 24-bit big-endian channel words, then two CRC bytes when crc_check_enable (register 0)
// was set at the first byte of the frame. Every byte before the CRC bytes passes through a
// CRC-16 (poly 0x8005, init 0xFFFF), and while a frame is being received a byte is taken
// every cycle. Finished channel words enter a row of CHANNELS sample cells that shift toward
// the output end. After the last byte of a frame the input is stalled while the results go
// out, one result per cycle the output is not stalled: the row is rotated out as CHANNELS
// results for a good frame, a single crc_error result for a bad one. Bytes after the frame
// end produce nothing until a byte with frame_start set.
module adc_frame_crc_parser_core #(
   parameter int CHANNELS     = afcp_pkg::DEF_CHANNELS,
   parameter int HEADER_BYTES = afcp_pkg::DEF_HEADER_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  afcp_pkg::in_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output afcp_pkg::out_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import afcp_pkg::*;

   localparam int DATA_LEN = HEADER_BYTES + 3 * CHANNELS;
   localparam int POS_W    = $clog2(DATA_LEN + 2);

   localparam logic [POS_W:0]  DATA_LEN_X = (POS_W + 1)'(DATA_LEN);
   localparam logic [POS_W:0]  HDR_X      = (POS_W + 1)'(HEADER_BYTES);
   localparam logic [CH_W-1:0] LAST_CH    = CH_W'(CHANNELS - 1);

   typedef enum logic [1:0] {ST_PARSE, ST_EMIT, ST_ERROR} state_type;

   state_type           state_ff;
   logic                enable_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [15:0]         crc_ff;
   logic [1:0]          k_ff;
   logic [15:0]         word_ff;
   logic [7:0]          rx_hi_ff;
   logic                done_ff;
   logic                latched_ff;
   logic [CH_W-1:0]     cnt_ff;
   logic                rsp_valid_ff;
   out_type             rsp_ff;

   logic [SAMPLE_W-1:0] cell_q [CHANNELS];
   cell_ctl_type        head_ctl;
   logic                shift_in;

   logic                accept;
   logic                rsp_free;
   logic [POS_W:0]      p_x;
   logic [15:0]         crc_cur;
   logic [1:0]          k_cur;
   logic                done_cur;
   logic                latched_in;
   logic [15:0]         crc_in;
   logic [POS_W:0]      frame_bytes;
   logic                is_data;
   logic                is_word;
   logic                frame_end;
   logic                crc_bad;
   logic [7:0]          b;

   assign b        = req_data.byte_value;
   assign accept   = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // a frame start byte sees a cleared frame
   assign p_x         = req_data.frame_start ? '0 : {1'b0, pos_ff};
   assign crc_cur     = req_data.frame_start ? CRC_INIT : crc_ff;
   assign k_cur       = req_data.frame_start ? 2'd0 : k_ff;
   assign done_cur    = req_data.frame_start ? 1'b0 : done_ff;
   assign latched_in  = (p_x == '0) ? enable_ff : latched_ff;
   assign crc_in      = crc_byte(crc_cur, b);
   assign frame_bytes = DATA_LEN_X + (latched_in ? (POS_W + 1)'(2) : '0);
   assign is_data     = p_x < DATA_LEN_X;
   assign is_word     = is_data && (p_x >= HDR_X);
   assign frame_end   = (p_x + 1'b1) >= frame_bytes;
   assign crc_bad     = latched_in && ({rx_hi_ff, b} != crc_cur);

   assign shift_in = accept && !done_cur && is_word && (k_cur == 2'd2);

   always_comb begin
      head_ctl.shift = shift_in;
      head_ctl.data  = {word_ff, b};
      if (state_ff == ST_EMIT) begin
         // rotate so the store survives the burst
         head_ctl.shift = rsp_free;
         head_ctl.data  = cell_q[CHANNELS-1];
      end
   end

   afcp_cell u_cell_0 (
      .clock    (clock),
      .ctl      (head_ctl),
      .data_out (cell_q[0])
   );

   for (genvar i = 1; i < CHANNELS; i++) begin : g_cell
      cell_ctl_type ctl;
      assign ctl.shift = head_ctl.shift;
      assign ctl.data  = cell_q[i-1];
      afcp_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .data_out (cell_q[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_PARSE;
         enable_ff    <= 1'b0;
         pos_ff       <= '0;
         crc_ff       <= CRC_INIT;
         k_ff         <= 2'd0;
         word_ff      <= '0;
         rx_hi_ff     <= '0;
         done_ff      <= 1'b0;
         latched_ff   <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
            enable_ff <= pwdata[0];
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_PARSE: begin
               if (accept && !done_cur) begin
                  latched_ff <= latched_in;
                  crc_ff     <= is_data ? crc_in : crc_cur;
                  if (is_word) begin
                     k_ff <= (k_cur == 2'd2) ? 2'd0 : k_cur + 2'd1;
                     if (k_cur == 2'd0) begin
                        word_ff <= {8'h00, b};
                     end else if (k_cur == 2'd1) begin
                        word_ff <= {word_ff[7:0], b};
                     end
                  end else begin
                     k_ff <= k_cur;
                  end
                  if (!is_data && (p_x == DATA_LEN_X)) begin
                     rx_hi_ff <= b;
                  end
                  if (frame_end) begin
                     done_ff  <= 1'b1;
                     pos_ff   <= p_x[POS_W-1:0];
                     cnt_ff   <= '0;
                     state_ff <= crc_bad ? ST_ERROR : ST_EMIT;
                  end else begin
                     done_ff <= 1'b0;
                     pos_ff  <= POS_W'(p_x + 1'b1);
                  end
               end
            end
            ST_EMIT: begin
               if (rsp_free) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_ff.channel    <= cnt_ff;
                  rsp_ff.sample     <= cell_q[CHANNELS-1];
                  rsp_ff.crc_error  <= 1'b0;
                  rsp_ff.last       <= (cnt_ff == LAST_CH);
                  if (cnt_ff == LAST_CH) begin
                     cnt_ff   <= '0;
                     state_ff <= ST_PARSE;
                  end else begin
                     cnt_ff <= cnt_ff + 1'b1;
                  end
               end
            end
            ST_ERROR: begin
               if (rsp_free) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_ff.channel    <= '0;
                  rsp_ff.sample     <= '0;
                  rsp_ff.crc_error  <= 1'b1;
                  rsp_ff.last       <= 1'b1;
                  state_ff          <= ST_PARSE;
               end
            end
            default: begin
               state_ff <= ST_PARSE;
            end
         endcase
      end
   end

   assign req_stall = (state_ff != ST_PARSE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign prdata    = {31'd0, enable_ff};
   assign pready    = 1'b1;

endmodule

/* verif/adc_frame_checker.sv */
module adc_frame_checker #(
   parameter logic [2:0] CRC_EN_ADDR = 3'd0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  afcp_pkg::in_type  req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  afcp_pkg::out_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   input  logic              pready,
   output int                failures,
   output int                outstanding
);

   localparam int NCH      = afcp_pkg::DEF_CHANNELS;
   localparam int HEADER   = afcp_pkg::DEF_HEADER_BYTES;
   localparam int DATA_LEN = HEADER + 3 * NCH;

   // parser state as the block should hold it
   logic [4:0]  byte_pos;
   logic [15:0] crc_acc;
   logic [15:0] word_hi;
   logic [23:0] samples [NCH];
   logic [7:0]  crc_hi;
   logic        frame_over;
   logic        crc_on_frame;
   logic        crc_enable;

   afcp_pkg::out_type frame_results [$];

   initial begin
      failures    = 0;
      outstanding = 0;
   end

   function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] d);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ d[i];
         c  = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ 16'h8005;
         end
      end
      return c;
   endfunction

   task automatic flag_error(input string msg);
      $display("%0t: %s", $time, msg);
      failures++;
   endtask

   task automatic parse_byte(input afcp_pkg::in_type it);
      int pos;
      int span;
      int q;
      afcp_pkg::out_type r;
      if (it.frame_start) begin
         byte_pos   = '0;
         crc_acc    = 16'hFFFF;
         word_hi    = '0;
         crc_hi     = '0;
         frame_over = 1'b0;
      end
      if (!frame_over) begin
         pos = byte_pos;
         if (pos == 0) begin
            crc_on_frame = crc_enable;
         end
         span = DATA_LEN + (crc_on_frame ? 2 : 0);
         if (pos < DATA_LEN) begin
            crc_acc = crc16_next(crc_acc, it.byte_value);
            if (pos >= HEADER) begin
               q = pos - HEADER;
               case (q % 3)
                  0: word_hi = {8'h00, it.byte_value};
                  1: word_hi = {word_hi[7:0], it.byte_value};
                  default: samples[q / 3] = {word_hi, it.byte_value};
               endcase
            end
         end else if (pos == DATA_LEN) begin
            crc_hi = it.byte_value;
         end
         if (pos + 1 >= span) begin
            frame_over = 1'b1;
            if (crc_on_frame && {crc_hi, it.byte_value} != crc_acc) begin
               r = '{channel: '0, sample: '0, crc_error: 1'b1, last: 1'b1};
               frame_results.push_back(r);
            end else begin
               for (int ch = 0; ch < NCH; ch++) begin
                  r.channel   = ch[2:0];
                  r.sample    = samples[ch];
                  r.crc_error = 1'b0;
                  r.last      = (ch == NCH - 1);
                  frame_results.push_back(r);
               end
            end
         end else begin
            byte_pos = 5'(pos + 1);
         end
      end
   endtask

   always @(posedge clock) begin
      afcp_pkg::out_type want;
      if (reset) begin
         byte_pos     = '0;
         crc_acc      = 16'hFFFF;
         word_hi      = '0;
         crc_hi       = '0;
         frame_over   = 1'b0;
         crc_on_frame = 1'b0;
         crc_enable   = 1'b0;
         frame_results.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr == CRC_EN_ADDR) begin
            crc_enable = pwdata[0];
         end
         if (rsp_valid && !rsp_stall) begin
            if (frame_results.size() == 0) begin
               flag_error($sformatf("result with nothing expected: ch %0d sample %h err %b last %b",
                                    rsp_data.channel, rsp_data.sample, rsp_data.crc_error,
                                    rsp_data.last));
            end else begin
               want = frame_results.pop_front();
               if (rsp_data.channel !== want.channel) begin
                  flag_error($sformatf("channel got %0d want %0d", rsp_data.channel,
                                       want.channel));
               end
               if (rsp_data.sample !== want.sample) begin
                  flag_error($sformatf("sample ch %0d got %h want %h", want.channel,
                                       rsp_data.sample, want.sample));
               end
               if (rsp_data.crc_error !== want.crc_error) begin
                  flag_error($sformatf("crc_error got %b want %b", rsp_data.crc_error,
                                       want.crc_error));
               end
               if (rsp_data.last !== want.last) begin
                  flag_error($sformatf("last ch %0d got %b want %b", want.channel,
                                       rsp_data.last, want.last));
               end
            end
         end
         // byte transfer
         if (req_valid && !req_stall) begin
            parse_byte(req_data);
         end
      end
      outstanding = frame_results.size();
   end

endmodule

/* verif/tb.sv */
module tb;

   localparam int NCH      = afcp_pkg::DEF_CHANNELS;
   localparam int HEADER   = afcp_pkg::DEF_HEADER_BYTES;
   localparam int DATA_LEN = HEADER + 3 * NCH;
   localparam int ITEMS    = 430;

   localparam logic [2:0] CRC_EN_ADDR = 3'd0;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   afcp_pkg::in_type  req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   afcp_pkg::out_type rsp_data;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [2:0]        paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   int   failures;
   int   outstanding;
   int   items_sent = 0;
   bit   crc_on = 1'b0;
   logic quiet = 1'b0;
   logic hold_req = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   adc_frame_crc_parser_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   adc_frame_checker #(.CRC_EN_ADDR(CRC_EN_ADDR)) u_chk (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .pready      (pready),
      .failures    (failures),
      .outstanding (outstanding)
   );

   // result side: random stalls, one long hold-off on request
   initial begin
      bit held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !held) begin
            rsp_stall <= 1'b1;
            repeat (160) @(posedge clock);
            held = 1'b1;
         end
         rsp_stall <= !quiet && ($urandom_range(99) < 24);
      end
   end

   task automatic send_byte(input logic [7:0] value, input logic start);
      if (!quiet && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{byte_value: value, frame_start: start};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // drop valid at the transfer edge, drain all results, then let the core go quiet
   task automatic settle();
      req_valid <= 1'b0;
      // let the checker see the last transfer before waiting for the drain
      @(posedge clock);
      wait (outstanding == 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_enable(input bit value);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= CRC_EN_ADDR;
      pwdata  <= {31'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      crc_on = value;
   endtask

   // cut > 0 sends only the first cut bytes; write_at flips the enable mid-frame
   task automatic send_frame(input int cut, input logic start, input bit corrupt,
                             input int write_at, input bit extremes);
      logic [7:0]  bytes [DATA_LEN + 2];
      logic [23:0] word;
      logic [15:0] c;
      logic        fb;
      int          len;
      int          k;
      bit          on;
      on = crc_on;
      for (int i = 0; i < HEADER; i++) begin
         bytes[i] = 8'($urandom_range(255));
      end
      for (int ch = 0; ch < NCH; ch++) begin
         case (extremes ? ch : int'($urandom_range(7)))
            0: word = 24'h800000;
            1: word = 24'h7FFFFF;
            2: word = 24'h000000;
            3: word = 24'hFFFFFF;
            default: word = 24'($urandom);
         endcase
         bytes[HEADER + 3 * ch]     = word[23:16];
         bytes[HEADER + 3 * ch + 1] = word[15:8];
         bytes[HEADER + 3 * ch + 2] = word[7:0];
      end
      c = 16'hFFFF;
      for (int i = 0; i < DATA_LEN; i++) begin
         for (int j = 7; j >= 0; j--) begin
            fb = c[15] ^ bytes[i][j];
            c  = {c[14:0], 1'b0} ^ (fb ? 16'h8005 : 16'h0000);
         end
      end
      bytes[DATA_LEN]     = c[15:8];
      bytes[DATA_LEN + 1] = c[7:0];
      len = on ? DATA_LEN + 2 : DATA_LEN;
      if (corrupt) begin
         k = $urandom_range(len - 1);
         bytes[k] = bytes[k] ^ (8'h01 << $urandom_range(7));
      end
      if (cut > 0) begin
         len = cut;
      end
      for (int i = 0; i < len; i++) begin
         if (i == write_at) begin
            settle();
            write_enable(!on);
         end
         send_byte(bytes[i], (i == 0) ? start : 1'b0);
      end
   endtask

   initial begin
      int frame_idx;
      int pick;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // first frame right after reset carries no start flag; extra bytes are ignored
      send_frame(0, 1'b0, 1'b0, -1, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);

      settle();
      write_enable(1'b1);
      frame_idx = 0;
      while (items_sent < ITEMS) begin
         if (frame_idx > 2 && $urandom_range(99) < 20) begin
            settle();
            write_enable(1'($urandom_range(1)));
         end
         if (frame_idx == 3) begin
            hold_req <= 1'b1;
         end
         quiet <= (frame_idx >= 6 && frame_idx <= 8);
         pick = $urandom_range(99);
         if (frame_idx < 3 || pick < 70) begin
            send_frame(0, 1'b1, frame_idx == 1 || pick < 15, (frame_idx == 2) ? 12 : -1,
                       frame_idx == 0);
         end else if (pick < 85) begin
            // broken frame, the next start restarts it
            send_frame($urandom_range(1, DATA_LEN - 1), 1'b1, 1'b0, -1, 1'b0);
         end else begin
            repeat ($urandom_range(1, 8)) begin
               send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
            end
         end
         if ($urandom_range(99) < 30) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
         end
         frame_idx++;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      repeat (20) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("adc_frame_crc_parser_core verification clean");
      end else begin
         $display("adc_frame_crc_parser_core verification failed");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("adc_frame_crc_parser_core verification failed");
      $finish;
   end

endmodule
